### src/cubic_hermite_evaluator_assert.svh
// Assertion macros for the cubic Hermite evaluator.
// Depends on nothing; the files that check their logic include it.
`ifndef CUBIC_HERMITE_EVALUATOR_ASSERT_SVH
`define CUBIC_HERMITE_EVALUATOR_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define CHE_ASSERT_SAME(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("cubic hermite evaluator: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger.
`define CHE_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("cubic hermite evaluator: next-cycle check failed");

`endif

### src/che_pkg.sv
// Shared constants of the cubic Hermite evaluator: field widths, command
// codes, register indexes and output limits. Depends on nothing.
package che_pkg;

  localparam int PARAM_T_W   = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_W       = 20;
  localparam int OUT_DATA_W  = 64;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;
  localparam int NUM_STAGES  = 7;

  localparam logic CMD_POSITION = 1'b0;
  localparam logic CMD_TANGENT  = 1'b1;

  localparam logic [1:0] REG_START_POINT   = 2'd0;
  localparam logic [1:0] REG_END_POINT     = 2'd1;
  localparam logic [1:0] REG_START_TANGENT = 2'd2;
  localparam logic [1:0] REG_END_TANGENT   = 2'd3;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sh7FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 20'sh80000;

  typedef logic [OUT_W-1:0] out_coord_t;

endpackage

### src/cubic_hermite_evaluator.sv
// Top level of the cubic Hermite evaluator: APB register file and the
// seven-stage evaluation pipeline. Depends on che_pkg and the assertion header.
//
// Usage:
//   Program the four segment vectors through the APB port (64-bit data):
//   start_point at 0x00, end_point at 0x08, start_tangent at 0x10,
//   end_tangent at 0x18. Each packs signed x, y, z coordinates with 8
//   fraction bits, x lowest. Write them only while no transfer is in flight.
//   Stream parameter samples on the in_ channel: in_tdata carries t
//   (T_FRAC_BITS fraction bits, clamped to one), in_tuser the command
//   (position or tangent). Each accepted transfer yields one out_ transfer
//   with signed Q12.8 x, y, z, saturated.
//   Throughput: one item per clock while out_tready is high. Each item passes
//   through the chain t -> t^2 -> t^3 -> weights -> products -> sums ->
//   round/saturate, one multiply or wide add per stage.
//   Each stage has its own valid bit and holds only while the stage after
//   it is full and stalled, so bubbles are squeezed out under backpressure;
//   in_tready drops only when every stage holds data and out_tready is low.
//   Reset (synchronous, rst_n low) clears all valid bits and the configuration registers.
`include "cubic_hermite_evaluator_assert.svh"

module cubic_hermite_evaluator #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 15
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // APB configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [che_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [che_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [che_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [che_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] param_t
  input  logic                           in_tuser,   // [0] command
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [che_pkg::OUT_DATA_W-1:0] out_tdata   // [19:0] x, [39:20] y, [59:40] z
);
  import che_pkg::*;

  localparam int TW    = T_FRAC_BITS + 1;
  localparam int PTW   = (TW > PARAM_T_W) ? TW : PARAM_T_W;
  localparam int SQW   = 2 * TW;
  localparam int WW    = TW + 3;
  localparam int PW    = WW + COORD_WIDTH;
  localparam int SUMW  = PW + 2;
  localparam int RW    = SUMW - T_FRAC_BITS;
  localparam int EW    = ((RW > OUT_W) ? RW : OUT_W) + 1;
  localparam int REG_W = 3 * COORD_WIDTH;

  localparam logic [PTW-1:0]         ONE_EXT = {{(PTW-1){1'b0}}, 1'b1} << T_FRAC_BITS;
  localparam logic [SQW-1:0]         HALF_SQ = {{(SQW-1){1'b0}}, 1'b1} << (T_FRAC_BITS - 1);
  localparam logic signed [WW-1:0]   ONE_W   = {{(WW-1){1'b0}}, 1'b1} << T_FRAC_BITS;
  localparam logic signed [SUMW-1:0] HALF_S  = {{(SUMW-1){1'b0}}, 1'b1} << (T_FRAC_BITS - 1);
  localparam logic signed [EW-1:0]   MAX_E   = EW'(OUT_MAX);
  localparam logic signed [EW-1:0]   MIN_E   = EW'(OUT_MIN);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [REG_W-1:0] p0_r, p1_r, m0_r, m1_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r <= '0;
      p1_r <= '0;
      m0_r <= '0;
      m1_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_POINT:   p0_r <= cfg_pwdata[REG_W-1:0];
        REG_END_POINT:     p1_r <= cfg_pwdata[REG_W-1:0];
        REG_START_TANGENT: m0_r <= cfg_pwdata[REG_W-1:0];
        REG_END_TANGENT:   m1_r <= cfg_pwdata[REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_START_POINT:   cfg_prdata = CFG_DATA_W'(p0_r);
      REG_END_POINT:     cfg_prdata = CFG_DATA_W'(p1_r);
      REG_START_TANGENT: cfg_prdata = CFG_DATA_W'(m0_r);
      REG_END_TANGENT:   cfg_prdata = CFG_DATA_W'(m1_r);
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its data moves on
  // ---------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] stg_en;

  always_comb begin
    stg_en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  assign in_tready = stg_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stg_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: clamp t to one
  // ---------------------------------------------------------------------
  logic [PTW-1:0] t_ext;
  logic [TW-1:0]  t_s1_r;
  logic           cmd_s1_r;

  assign t_ext = PTW'(in_tdata[PARAM_T_W-1:0]);

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      t_s1_r   <= (t_ext > ONE_EXT) ? ONE_EXT[TW-1:0] : t_ext[TW-1:0];
      cmd_s1_r <= in_tuser;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: t^2, rounded half up
  // ---------------------------------------------------------------------
  logic [SQW-1:0] sq;
  logic [TW-1:0]  t_s2_r, t2_s2_r;
  logic           cmd_s2_r;

  assign sq = SQW'(t_s1_r) * SQW'(t_s1_r) + HALF_SQ;

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      t_s2_r   <= t_s1_r;
      t2_s2_r  <= sq[T_FRAC_BITS +: TW];
      cmd_s2_r <= cmd_s1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: t^3 from the rounded square
  // ---------------------------------------------------------------------
  logic [SQW-1:0] cu;
  logic [TW-1:0]  t_s3_r, t2_s3_r, t3_s3_r;
  logic           cmd_s3_r;

  assign cu = SQW'(t2_s2_r) * SQW'(t_s2_r) + HALF_SQ;

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      t_s3_r   <= t_s2_r;
      t2_s3_r  <= t2_s2_r;
      t3_s3_r  <= cu[T_FRAC_BITS +: TW];
      cmd_s3_r <= cmd_s2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: basis weights (position) or their derivatives (tangent)
  // ---------------------------------------------------------------------
  logic signed [WW-1:0] ts, t2s, t3s;
  logic signed [WW-1:0] wp0, wm0, wp1, wm1;
  logic signed [WW-1:0] wp0_s4_r, wm0_s4_r, wp1_s4_r, wm1_s4_r;

  assign ts  = $signed({3'b000, t_s3_r});
  assign t2s = $signed({3'b000, t2_s3_r});
  assign t3s = $signed({3'b000, t3_s3_r});

  always_comb begin
    unique case (cmd_s3_r)
      CMD_POSITION: begin
        wp0 = (t3s <<< 1) - (t2s <<< 1) - t2s + ONE_W;
        wm0 = t3s - (t2s <<< 1) + ts;
        wp1 = ONE_W - wp0;
        wm1 = t3s - t2s;
      end
      CMD_TANGENT: begin
        wp0 = ((t2s - ts) <<< 2) + ((t2s - ts) <<< 1);
        wp1 = -wp0;
        wm0 = (t2s <<< 1) + t2s - (ts <<< 2) + ONE_W;
        wm1 = (t2s <<< 1) + t2s - (ts <<< 1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      wp0_s4_r <= wp0;
      wm0_s4_r <= wm0;
      wp1_s4_r <= wp1;
      wm1_s4_r <= wm1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: twelve weight-by-coordinate products
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] prod_p0_r [3];
  logic signed [PW-1:0] prod_m0_r [3];
  logic signed [PW-1:0] prod_p1_r [3];
  logic signed [PW-1:0] prod_m1_r [3];

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      for (int i = 0; i < 3; i++) begin
        prod_p0_r[i] <= PW'(wp0_s4_r)
                      * PW'($signed(p0_r[i*COORD_WIDTH +: COORD_WIDTH]));
        prod_m0_r[i] <= PW'(wm0_s4_r)
                      * PW'($signed(m0_r[i*COORD_WIDTH +: COORD_WIDTH]));
        prod_p1_r[i] <= PW'(wp1_s4_r)
                      * PW'($signed(p1_r[i*COORD_WIDTH +: COORD_WIDTH]));
        prod_m1_r[i] <= PW'(wm1_s4_r)
                      * PW'($signed(m1_r[i*COORD_WIDTH +: COORD_WIDTH]));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: sum the four terms of each axis
  // ---------------------------------------------------------------------
  logic signed [SUMW-1:0] sum_r [3];

  always_ff @(posedge clk) begin
    if (stg_en[5]) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= SUMW'(prod_p0_r[i]) + SUMW'(prod_m0_r[i])
                  + SUMW'(prod_p1_r[i]) + SUMW'(prod_m1_r[i]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: round half up, drop fraction bits, saturate to Q12.8
  // ---------------------------------------------------------------------
  logic signed [SUMW-1:0] rnd_full [3];
  logic signed [EW-1:0]   rnd_ext  [3];
  out_coord_t             sat      [3];
  out_coord_t             res_r    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_full[i] = (sum_r[i] + HALF_S) >>> T_FRAC_BITS;
      rnd_ext[i]  = EW'($signed(rnd_full[i][RW-1:0]));
      priority if (rnd_ext[i] > MAX_E) begin
        sat[i] = OUT_MAX;
      end else if (rnd_ext[i] < MIN_E) begin
        sat[i] = OUT_MIN;
      end else begin
        sat[i] = rnd_ext[i][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[6]) begin
      for (int i = 0; i < 3; i++) begin
        res_r[i] <= sat[i];
      end
    end
  end

  assign out_tvalid = vld_r[NUM_STAGES-1];
  assign out_tdata  = {{(OUT_DATA_W - 3*OUT_W){1'b0}}, res_r[2], res_r[1], res_r[0]};

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // Backpressure reaches the input only when the output is stalled.
  `CHE_ASSERT_SAME(a_stall_source, clk, rst_n, !in_tready, out_tvalid && !out_tready)
  // A blocked input means every stage holds an item.
  `CHE_ASSERT_SAME(a_full_when_blocked, clk, rst_n, !stg_en[0], &vld_r)
  // The clamped parameter never exceeds one.
  `CHE_ASSERT_SAME(a_t_clamped, clk, rst_n, vld_r[0], TW'(t_s1_r) <= ONE_EXT[TW-1:0])
  // Squaring a value at most one cannot grow it.
  `CHE_ASSERT_SAME(a_t2_bound, clk, rst_n, vld_r[1], t2_s2_r <= t_s2_r)
  // A stalled result keeps its payload.
  `CHE_ASSERT_NEXT(a_hold_result, clk, rst_n, out_tvalid && !out_tready,
                   $stable(out_tdata))

endmodule

### tb/cubic_hermite_evaluator_test.sv
// Self-checking bench for the cubic Hermite evaluator: programs segments over APB,
// streams parameter samples and checks every result against an in-bench predictor.
// Depends on che_pkg and the cubic_hermite_evaluator RTL.
`timescale 1ns / 1ps

module cubic_hermite_evaluator_test;
  import che_pkg::*;

  localparam int T_ONE  = 32768;  // 1.0 in Q1.15
  localparam int T_HALF = 16384;  // rounding bias for a 15-bit shift

  typedef struct packed {
    logic        cmd;
    logic [15:0] t;
  } sample_t;

  // x in [19:0], y in [39:20], z in [59:40], matching out_tdata
  typedef logic [3*OUT_W-1:0] coord_triple_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // [15:0] param_t
  logic                  in_tuser = 1'b0;  // [0] command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [19:0] x, [39:20] y, [59:40] z

  // Bench copy of the segment registers, updated as each APB write completes
  logic [63:0] seg_p0 = '0;
  logic [63:0] seg_p1 = '0;
  logic [63:0] seg_m0 = '0;
  logic [63:0] seg_m1 = '0;

  sample_t       sample_q[$];        // samples waiting to be driven
  coord_triple_t curve_results_q[$]; // predicted results, oldest first
  sample_t       drive_item;

  int  queued_cnt = 0;
  int  accepted_cnt = 0;
  int  err_cnt = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  bit  no_idle = 1'b0;

  cubic_hermite_evaluator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #1500000;
    $display("*** FAILED ***");
    $finish;
  end

  // Sign-extend one Q8.8 coordinate out of a packed segment register
  function automatic longint seg_coord(input logic [63:0] reg_v, input int idx);
    logic signed [15:0] c;
    c = reg_v[idx*16 +: 16];
    return longint'(c);
  endfunction

  // Evaluate the segment at t: position for CMD_POSITION, tangent otherwise
  function automatic coord_triple_t hermite_eval(input logic cmd, input logic [15:0] t_raw);
    longint t, t2, t3;
    longint w_p0, w_m0, w_p1, w_m1;
    longint acc, r;
    coord_triple_t res;
    // clamp t above one to exactly one
    t  = (t_raw > 16'(T_ONE)) ? longint'(T_ONE) : longint'(t_raw);
    t2 = (t * t + T_HALF) >>> 15;
    t3 = (t2 * t + T_HALF) >>> 15;
    if (cmd == CMD_POSITION) begin
      w_p0 = 2 * t3 - 3 * t2 + T_ONE;
      w_m0 = t3 - 2 * t2 + t;
      w_p1 = T_ONE - w_p0;
      w_m1 = t3 - t2;
    end else begin
      w_p0 = 6 * (t2 - t);
      w_p1 = -w_p0;
      w_m0 = 3 * t2 - 4 * t + T_ONE;
      w_m1 = 3 * t2 - 2 * t;
    end
    for (int i = 0; i < 3; i++) begin
      acc = w_p0 * seg_coord(seg_p0, i) + w_m0 * seg_coord(seg_m0, i)
          + w_p1 * seg_coord(seg_p1, i) + w_m1 * seg_coord(seg_m1, i);
      // arithmetic shift floors, so adding the half first rounds half up
      r = (acc + T_HALF) >>> 15;
      if (r > longint'(OUT_MAX)) r = longint'(OUT_MAX);
      if (r < longint'(OUT_MIN)) r = longint'(OUT_MIN);
      res[i*OUT_W +: OUT_W] = r[OUT_W-1:0];
    end
    return res;
  endfunction

  // Idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: advance to the next queued sample once the current transfer is done,
  // predict its result at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        curve_results_q.push_back(hermite_eval(in_tuser, in_tdata));
        accepted_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap--;
        end else if (sample_q.size() > 0) begin
          drive_item = sample_q.pop_front();
          in_tdata  <= drive_item.t;
          in_tuser  <= drive_item.cmd;
          in_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction, then
  // choose whether to stall the next cycle.
  always @(posedge clk) begin
    coord_triple_t want;
    logic [OUT_W-1:0] got_f, want_f;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (curve_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $realtime,
                   out_tdata[3*OUT_W-1:0]);
          err_cnt++;
        end else begin
          want = curve_results_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            got_f  = out_tdata[i*OUT_W +: OUT_W];
            want_f = want[i*OUT_W +: OUT_W];
            if (got_f !== want_f) begin
              $display("%0t: coord %0d mismatch, expected %h, actual %h", $realtime, i,
                       want_f, got_f);
              err_cnt++;
            end
          end
        end
      end
      if (recv_stall > 0) begin
        out_tready <= 1'b0;
        recv_stall--;
      end else begin
        out_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 25) recv_stall = pick_gap();
      end
    end
  end

  // APB write: setup cycle, then access cycle held until pready
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_START_POINT:   seg_p0 = value;
      REG_END_POINT:     seg_p1 = value;
      REG_START_TANGENT: seg_m0 = value;
      default:           seg_m1 = value;
    endcase
  endtask

  // Program a whole segment; the top 16 bits carry junk that must be ignored
  task automatic load_segment(input logic [47:0] p0, input logic [47:0] p1,
                              input logic [47:0] m0, input logic [47:0] m1);
    write_reg(REG_START_POINT,   {16'($urandom), p0});
    write_reg(REG_END_POINT,     {16'($urandom), p1});
    write_reg(REG_START_TANGENT, {16'($urandom), m0});
    write_reg(REG_END_TANGENT,   {16'($urandom), m1});
  endtask

  task automatic queue_sample(input logic cmd, input logic [15:0] t);
    sample_t s;
    s.cmd = cmd;
    s.t   = t;
    sample_q.push_back(s);
    queued_cnt++;
  endtask

  // Random sample: mostly legal t, some edges, some above one
  task automatic queue_random_sample();
    int r;
    logic [15:0] t;
    r = $urandom_range(0, 99);
    if (r < 70)      t = 16'($urandom_range(0, T_ONE));
    else if (r < 80) t = (r % 2) ? 16'(T_ONE - (r % 3)) : 16'(r % 3);
    else             t = 16'($urandom_range(0, 65535));
    queue_sample($urandom_range(0, 1) ? CMD_TANGENT : CMD_POSITION, t);
  endtask

  // Hold until every queued sample has transferred and every result has come
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || curve_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [47:0] random_vec();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  initial begin
    logic [15:0] edge_t[9];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset value: everything evaluates to zero
    queue_sample(CMD_POSITION, 16'd0);
    queue_sample(CMD_TANGENT, 16'd0);
    queue_sample(CMD_POSITION, 16'(T_ONE));
    queue_sample(CMD_TANGENT, 16'(T_ONE));
    wait_drained();

    // Directed sweep: coordinate extremes in every register, t at its edges,
    // just past one and at the top of the field, both commands.
    load_segment({16'h8000, 16'h7FFF, 16'h0100}, {16'h7FFF, 16'h8000, 16'hFF00},
                 {16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000});
    edge_t = '{16'd0, 16'd1, 16'd8192, 16'd16384, 16'd24576, 16'd32767,
               16'd32768, 16'd32769, 16'hFFFF};
    foreach (edge_t[k]) begin
      queue_sample(CMD_POSITION, edge_t[k]);
      queue_sample(CMD_TANGENT, edge_t[k]);
    end
    wait_drained();

    // Random phases, each with its own segment
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: load_segment({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        1: load_segment({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        2: load_segment({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h7FFF}});
        5: load_segment(48'd0, 48'd0, 48'd0, 48'd0);
        default: load_segment(random_vec(), random_vec(), random_vec(), random_vec());
      endcase
      // a couple of phases run back to back with no idling on either side
      no_idle = (ph == 4 || ph == 7);
      for (int n = 0; n < 175; n++) begin
        queue_random_sample();
        // sender pauses mid-phase until the pipeline has emptied
        if (ph == 3 && n == 87) wait_drained();
      end
      wait_drained();
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (4 * NUM_STAGES) @(posedge clk);
    if (err_cnt == 0 && curve_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
